### design/sorted_key_priority_list_unit_macros.svh
// Assertion macros for the sorted key priority list unit
`ifndef SORTED_KEY_PRIORITY_LIST_UNIT_MACROS_SVH
`define SORTED_KEY_PRIORITY_LIST_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset
`define SKPL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("skpl: same-cycle property violated");

// Next-cycle implication, checked on every rising clock edge out of reset
`define SKPL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("skpl: next-cycle property violated");

`endif

### design/skpl_pkg.sv
// Types and constants shared by the sorted key priority list unit
package skpl_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 16;
  localparam int OCC_W = 5;

  typedef enum logic [1:0] {
    REQ_INSERT    = 2'd0,
    REQ_POP       = 2'd1,
    REQ_REMOVE_LE = 2'd2,
    REQ_REMOVE_EQ = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_NONE  = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic              match;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } cell_ctl_t;

  typedef struct packed {
    logic le;
    logic shift;
    logic hit;
  } cell_flags_t;

endpackage

### design/skpl_cell.sv
// One slot of the sorted chain: holds an entry and trades it with its neighbours
module skpl_cell import skpl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctl_t         ctl,
  input  logic              left_le,
  input  logic              left_shift,
  input  logic              left_valid,
  input  logic [KEY_W-1:0]  left_key,
  input  logic [VAL_W-1:0]  left_value,
  input  logic              right_valid,
  input  logic [KEY_W-1:0]  right_key,
  input  logic [VAL_W-1:0]  right_value,
  output logic              valid,
  output logic [KEY_W-1:0]  key,
  output logic [VAL_W-1:0]  value,
  output cell_flags_t       flags
);

  logic             valid_r, valid_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] value_r, value_nxt;

  always_comb begin
    flags.le    = valid_r && (key_r <= ctl.key);
    flags.hit   = ctl.match && valid_r && (key_r == ctl.key);
    flags.shift = left_shift || flags.hit;
    valid_nxt   = valid_r;
    key_nxt     = key_r;
    value_nxt   = value_r;
    case (ctl.op)
      CELL_INSERT: begin
        if (!flags.le) begin
          if (left_le) begin
            valid_nxt = 1'b1;
            key_nxt   = ctl.key;
            value_nxt = ctl.value;
          end else begin
            valid_nxt = left_valid;
            key_nxt   = left_key;
            value_nxt = left_value;
          end
        end
      end
      CELL_REMOVE: begin
        if (flags.shift) begin
          valid_nxt = right_valid;
          key_nxt   = right_key;
          value_nxt = right_value;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

  assign valid = valid_r;
  assign key   = key_r;
  assign value = value_r;

endmodule

### design/sorted_key_priority_list_unit.sv
// Sorted key priority list: a chain of entry cells and its request sequencer
// A taken start registers the request and enters S_EXEC; each result is registered from S_EXEC.
// Insert and pop give one result; a removal of n entries gives one result
// a cycle, n in all (a single ST_NONE result when nothing matches).
// Each cycle the chain settles one insert or one removal in every cell at once.
// Synchronous reset empties every cell and clears the count; busy is low after.
`include "sorted_key_priority_list_unit_macros.svh"
module sorted_key_priority_list_unit import skpl_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_req_type,
  input  logic [KEY_W-1:0]  in_req_key,
  input  logic [VAL_W-1:0]  in_req_value,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [KEY_W-1:0]  out_key,
  output logic [VAL_W-1:0]  out_value,
  output logic [OCC_W-1:0]  out_occupancy,
  output logic              out_last_result
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  req_type_t        req_type_r;
  logic [KEY_W-1:0] req_key_r;
  logic [VAL_W-1:0] req_value_r;

  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  logic [KEY_W-1:0] out_key_r, out_key_nxt;
  logic [VAL_W-1:0] out_value_r, out_value_nxt;
  logic [OCC_W-1:0] out_occ_r, out_occ_nxt;
  logic             out_last_r, out_last_nxt;

  cell_ctl_t        ctl;
  logic [CAPACITY:0] cell_valid;
  logic [KEY_W-1:0] cell_key [CAPACITY+1];
  logic [VAL_W-1:0] cell_value [CAPACITY+1];
  cell_flags_t      flg [CAPACITY];
  logic [CAPACITY-1:0] hit_v;
  logic [CAPACITY-1:0] first_v;
  logic [CAPACITY:0] le_c;
  logic [CAPACITY:0] shift_c;

  logic             accept;
  logic             head_le;
  logic             next_le;
  logic             more_hits;
  logic [VAL_W-1:0] hit_value;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  // right-hand boundary of the chain reads as an empty slot
  assign cell_valid[CAPACITY] = 1'b0;
  assign cell_key[CAPACITY]   = '0;
  assign cell_value[CAPACITY] = '0;
  assign le_c[0]    = 1'b1;
  assign shift_c[0] = !ctl.match;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             lv;
    logic [KEY_W-1:0] lk;
    logic [VAL_W-1:0] lval;
    if (i == 0) begin : g_head
      assign lv   = 1'b0;
      assign lk   = '0;
      assign lval = '0;
    end else begin : g_body
      assign lv   = cell_valid[i-1];
      assign lk   = cell_key[i-1];
      assign lval = cell_value[i-1];
    end
    skpl_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .left_le     (le_c[i]),
      .left_shift  (shift_c[i]),
      .left_valid  (lv),
      .left_key    (lk),
      .left_value  (lval),
      .right_valid (cell_valid[i+1]),
      .right_key   (cell_key[i+1]),
      .right_value (cell_value[i+1]),
      .valid       (cell_valid[i]),
      .key         (cell_key[i]),
      .value       (cell_value[i]),
      .flags       (flg[i])
    );
    assign le_c[i+1]    = flg[i].le;
    assign shift_c[i+1] = flg[i].shift;
    assign hit_v[i]     = flg[i].hit;
    assign first_v[i]   = flg[i].hit && !shift_c[i];
  end

  always_comb begin
    hit_value = '0;
    more_hits = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_value = hit_value | (cell_value[i] & {VAL_W{first_v[i]}});
    end
    for (int i = 1; i < CAPACITY; i++) begin
      more_hits = more_hits | (hit_v[i] && hit_v[i-1]);
    end
  end

  assign head_le = cell_valid[0] && (cell_key[0] <= req_key_r);
  assign next_le = cell_valid[1] && (cell_key[1] <= req_key_r);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ctl.op         = CELL_HOLD;
    ctl.match      = (req_type_r == REQ_REMOVE_EQ);
    ctl.key        = req_key_r;
    ctl.value      = req_value_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = ST_OK;
    out_key_nxt    = '0;
    out_value_nxt  = '0;
    out_occ_nxt    = OCC_W'(count_r);
    out_last_nxt   = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        case (req_type_r)
          REQ_INSERT: begin
            if (count_r == CNT_W'(CAPACITY)) begin
              out_status_nxt = ST_FULL;
            end else begin
              ctl.op      = CELL_INSERT;
              count_nxt   = count_r + CNT_W'(1);
              out_occ_nxt = OCC_W'(count_nxt);
            end
          end
          REQ_POP: begin
            if (count_r == '0) begin
              out_status_nxt = ST_EMPTY;
            end else begin
              ctl.op        = CELL_REMOVE;
              count_nxt     = count_r - CNT_W'(1);
              out_key_nxt   = cell_key[0];
              out_value_nxt = cell_value[0];
              out_occ_nxt   = OCC_W'(count_nxt);
            end
          end
          REQ_REMOVE_LE: begin
            if (head_le) begin
              ctl.op        = CELL_REMOVE;
              count_nxt     = count_r - CNT_W'(1);
              out_key_nxt   = cell_key[0];
              out_value_nxt = cell_value[0];
              out_occ_nxt   = OCC_W'(count_nxt);
              out_last_nxt  = !next_le;
              if (next_le) begin
                state_nxt = S_EXEC;
              end
            end else begin
              out_status_nxt = ST_NONE;
            end
          end
          REQ_REMOVE_EQ: begin
            if (|hit_v) begin
              ctl.op        = CELL_REMOVE;
              count_nxt     = count_r - CNT_W'(1);
              out_key_nxt   = req_key_r;
              out_value_nxt = hit_value;
              out_occ_nxt   = OCC_W'(count_nxt);
              out_last_nxt  = !more_hits;
              if (more_hits) begin
                state_nxt = S_EXEC;
              end
            end else begin
              out_status_nxt = ST_NONE;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_type_r  <= req_type_t'(in_req_type);
      req_key_r   <= in_req_key;
      req_value_r <= in_req_value;
    end
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_value_r  <= out_value_nxt;
    out_occ_r    <= out_occ_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_key         = out_key_r;
  assign out_value       = out_value_r;
  assign out_occupancy   = out_occ_r;
  assign out_last_result = out_last_r;

  `SKPL_ASSERT_IMP(a_count_matches_cells, 1'b1, $countones(cell_valid) == int'(count_r))
  `SKPL_ASSERT_IMP(a_count_in_range, 1'b1, count_r <= CNT_W'(CAPACITY))
  `SKPL_ASSERT_NXT(a_accept_goes_busy, accept, busy)
  `SKPL_ASSERT_IMP(a_more_results_busy, out_valid && !out_last_result, busy)
  `SKPL_ASSERT_IMP(a_last_result_frees, out_valid && out_last_result, !busy)

endmodule
